### rtl/core/jsi_pkg.sv
package jsi_pkg;

  localparam int TICK_MS_DEF = 10;

  // Width of the per-tick position increment. It covers |speed|, which bounds
  // speed * TICK_MS / 1000 for any tick of at most one second.
  localparam int STEP_W = 25;

  localparam logic [4:0] KEY_RUN       = 5'd4;
  localparam logic [4:0] KEY_ROLL_ZERO = 5'd9;

  localparam logic [7:0] STICK_HI     = 8'd192;
  localparam logic [7:0] STICK_LO     = 8'd64;
  localparam logic [7:0] X_CENTER     = 8'd127;
  localparam logic [7:0] Y_CENTER     = 8'd128;

  // Q8.24 gains and limits
  localparam logic signed [24:0] SPEED_GAIN = -25'sd83886;
  localparam logic signed [19:0] TURN_GAIN  = -20'sd3355;
  localparam logic signed [18:0] ROLL_GAIN  = 19'sd1174;
  localparam logic signed [16:0] LEG_GAIN   = -17'sd252;
  localparam logic signed [24:0] ROLL_LIMIT = 25'sd6710887;
  localparam logic [21:0]        LEG_MIN    = 22'd1090519;
  localparam logic [21:0]        LEG_MAX    = 22'd3019899;
  localparam logic [21:0]        LEG_REST   = 22'd1342177;
  localparam logic signed [22:0] LEG_THRESH = 23'sd1677;
  localparam logic signed [32:0] PITCH_LO   = 33'sd13176795;
  localparam logic signed [32:0] PITCH_HI   = 33'sd26353589;

  typedef struct packed {
    logic [4:0]         key_code;
    logic [7:0]         left_x;
    logic [7:0]         left_y;
    logic [7:0]         right_x;
    logic [7:0]         right_y;
    logic signed [31:0] body_pitch;
    logic signed [31:0] position_estimate;
    logic signed [31:0] yaw_total;
  } poll_t;

  typedef struct packed {
    logic signed [31:0] speed_target;
    logic signed [31:0] position_target;
    logic signed [31:0] turn_target;
    logic signed [23:0] roll_target;
    logic [21:0]        leg_target;
    logic               run_mode;
    logic               recover_request;
    logic               leg_changing;
  } setpt_t;

  typedef struct packed {
    logic [4:0]         previous_key;
    logic               running;
    logic               recovering;
    logic signed [31:0] position_accum;
    logic signed [31:0] heading_accum;
    logic signed [23:0] roll_accum;
    logic [21:0]        leg_accum;
    logic [21:0]        previous_leg;
  } state_t;

  localparam state_t STATE_RESET = '{
    previous_key:   5'd0,
    running:        1'b0,
    recovering:     1'b0,
    position_accum: 32'sd0,
    heading_accum:  32'sd0,
    roll_accum:     24'sd0,
    leg_accum:      LEG_REST,
    previous_leg:   22'd0
  };

endpackage

### rtl/core/jsi_if.sv
interface jsi_poll_if;
  logic            valid;
  logic            ready;
  jsi_pkg::poll_t  data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface jsi_setpt_if;
  logic             valid;
  logic             ready;
  jsi_pkg::setpt_t  data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/core/jsi_step.sv
module jsi_step #(
  parameter int TICK_MS = jsi_pkg::TICK_MS_DEF
) (
  input  jsi_pkg::poll_t  item,
  input  jsi_pkg::state_t cur,
  output jsi_pkg::state_t nxt,
  output jsi_pkg::setpt_t res
);

  // Position increment per right-Y byte, truncated toward zero; built at elaboration.
  logic signed [jsi_pkg::STEP_W-1:0] step_tab [256];

  for (genvar i = 0; i < 256; i++) begin : g_step
    localparam longint StepVal =
      (longint'(i) - 64'sd128) * longint'(jsi_pkg::SPEED_GAIN) * longint'(TICK_MS) / 64'sd1000;
    assign step_tab[i] = jsi_pkg::STEP_W'(StepVal);
  end

  logic [7:0]         rx;
  logic [7:0]         ry;
  logic               toggle;
  logic signed [32:0] pitch_ext;
  logic signed [32:0] pitch_abs;
  logic               tipped;
  logic               run_next;
  logic               rec_next;
  logic signed [8:0]  ry_c;
  logic signed [8:0]  rx_c;
  logic signed [8:0]  lx_c;
  logic signed [8:0]  ly_c;
  logic signed [24:0] speed;
  logic signed [19:0] turn_inc;
  logic signed [18:0] roll_inc;
  logic signed [16:0] leg_inc;
  logic signed [32:0] psum;
  logic signed [32:0] hsum;
  logic signed [24:0] rsum;
  logic signed [23:0] lsum;
  logic signed [31:0] pos_run;
  logic signed [31:0] head_run;
  logic signed [23:0] roll_run;
  logic [21:0]        leg_run;
  logic signed [22:0] ldiff;
  logic               leg_chg;

  always_comb begin
    // cross-axis lockout: right Y wins over right X
    rx = item.right_x;
    if (item.right_y > jsi_pkg::STICK_HI || item.right_y < jsi_pkg::STICK_LO) begin
      rx = jsi_pkg::X_CENTER;
    end
    ry = item.right_y;
    if (rx > jsi_pkg::STICK_HI || rx < jsi_pkg::STICK_LO) begin
      ry = jsi_pkg::Y_CENTER;
    end

    toggle    = (cur.previous_key != jsi_pkg::KEY_RUN) && (item.key_code == jsi_pkg::KEY_RUN);
    pitch_ext = 33'(item.body_pitch);
    pitch_abs = pitch_ext[32] ? -pitch_ext : pitch_ext;
    tipped    = (pitch_abs >= jsi_pkg::PITCH_LO) && (pitch_abs <= jsi_pkg::PITCH_HI);

    run_next = cur.running;
    rec_next = cur.recovering;
    if (toggle) begin
      if (!cur.running) begin
        run_next = 1'b1;
        rec_next = cur.recovering | tipped;
      end else begin
        run_next = 1'b0;
        rec_next = 1'b0;
      end
    end

    ry_c = $signed({1'b0, ry}) - $signed({1'b0, jsi_pkg::Y_CENTER});
    rx_c = $signed({1'b0, rx}) - $signed({1'b0, jsi_pkg::X_CENTER});
    lx_c = $signed({1'b0, item.left_x}) - $signed({1'b0, jsi_pkg::X_CENTER});
    ly_c = $signed({1'b0, item.left_y}) - $signed({1'b0, jsi_pkg::Y_CENTER});

    speed    = 25'(ry_c) * jsi_pkg::SPEED_GAIN;
    turn_inc = 20'(rx_c) * jsi_pkg::TURN_GAIN;
    roll_inc = 19'(lx_c) * jsi_pkg::ROLL_GAIN;
    leg_inc  = 17'(ly_c) * jsi_pkg::LEG_GAIN;

    // saturating integrators: for position and heading, overflow shows as bits 32 and 31 differing
    psum = 33'(cur.position_accum) + 33'(step_tab[ry]);
    if (psum[32] != psum[31]) begin
      pos_run = psum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      pos_run = psum[31:0];
    end

    hsum = 33'(cur.heading_accum) + 33'(turn_inc);
    if (hsum[32] != hsum[31]) begin
      head_run = hsum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      head_run = hsum[31:0];
    end

    rsum = 25'(cur.roll_accum) + 25'(roll_inc);
    if (rsum > jsi_pkg::ROLL_LIMIT) begin
      roll_run = 24'(jsi_pkg::ROLL_LIMIT);
    end else if (rsum < -jsi_pkg::ROLL_LIMIT) begin
      roll_run = 24'(-jsi_pkg::ROLL_LIMIT);
    end else begin
      roll_run = rsum[23:0];
    end

    lsum = $signed({2'b00, cur.leg_accum}) + 24'(leg_inc);
    if (lsum < $signed({2'b00, jsi_pkg::LEG_MIN})) begin
      leg_run = jsi_pkg::LEG_MIN;
    end else if (lsum > $signed({2'b00, jsi_pkg::LEG_MAX})) begin
      leg_run = jsi_pkg::LEG_MAX;
    end else begin
      leg_run = lsum[21:0];
    end

    ldiff   = $signed({1'b0, cur.previous_leg}) - $signed({1'b0, leg_run});
    leg_chg = (ldiff > jsi_pkg::LEG_THRESH) || (ldiff < -jsi_pkg::LEG_THRESH);

    nxt.previous_key = item.key_code;
    nxt.running      = run_next;
    nxt.recovering   = rec_next;
    if (run_next) begin
      nxt.position_accum = pos_run;
      nxt.heading_accum  = head_run;
      nxt.roll_accum     = roll_run;
      nxt.leg_accum      = leg_run;
      nxt.previous_leg   = leg_run;
    end else begin
      nxt.position_accum = item.position_estimate;
      nxt.heading_accum  = item.yaw_total;
      nxt.roll_accum     = 24'sd0;
      nxt.leg_accum      = jsi_pkg::LEG_REST;
      nxt.previous_leg   = cur.previous_leg;
    end
    if (item.key_code == jsi_pkg::KEY_ROLL_ZERO) begin
      nxt.roll_accum = 24'sd0;
    end

    res.speed_target    = run_next ? 32'(speed) : 32'sd0;
    res.position_target = nxt.position_accum;
    res.turn_target     = nxt.heading_accum;
    res.roll_target     = nxt.roll_accum;
    res.leg_target      = nxt.leg_accum;
    res.run_mode        = run_next;
    res.recover_request = rec_next;
    res.leg_changing    = run_next & leg_chg;
  end

endmodule

### rtl/core/joystick_setpoint_integrator.sv
// Joystick setpoint integrator.
// poll (sink): one joystick poll per request, with key code, four stick bytes,
//   body pitch, position estimate and total yaw.
// setpt (source): one setpoint set per poll, in poll order.
// Both channels move a request at a clock edge where valid and ready are high.
// A poll is held in an input register, then one pass of constant multiplies,
// adds and clamps updates the integrator state and loads the result register.
// Throughput: one poll per cycle; the input register stops only when both it and
// the result register are full and setpt is not ready.
// The per-tick position step comes from a 256-entry constant table on right Y.
// When setpt stalls, the result holds, one more poll is buffered, then poll
// ready drops.
// rst (synchronous) empties both registers, stops run mode, clears recovery
// and the integrators, and puts the leg setpoint at its 0.08 m rest value.
module joystick_setpoint_integrator #(
  parameter int TICK_MS = jsi_pkg::TICK_MS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  jsi_poll_if.sink     poll,
  jsi_setpt_if.source  setpt
);

  logic             s1_valid;
  jsi_pkg::poll_t   s1_item;
  logic             out_valid;
  jsi_pkg::setpt_t  out_data;
  jsi_pkg::state_t  state;
  jsi_pkg::state_t  state_next;
  jsi_pkg::setpt_t  result;
  logic             advance;

  jsi_step #(
    .TICK_MS(TICK_MS)
  ) u_step (
    .item(s1_item),
    .cur (state),
    .nxt (state_next),
    .res (result)
  );

  assign advance     = s1_valid && (!out_valid || setpt.ready);
  assign poll.ready  = !s1_valid || advance;
  assign setpt.valid = out_valid;
  assign setpt.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= jsi_pkg::STATE_RESET;
    end else begin
      if (poll.ready) begin
        s1_valid <= poll.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (setpt.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      s1_item <= poll.data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

  a_rec_needs_run: assert property (@(posedge clk) disable iff (rst)
    state.recovering |-> state.running)
    else $error("recovery armed while stopped");

  a_leg_range: assert property (@(posedge clk) disable iff (rst)
    state.leg_accum >= jsi_pkg::LEG_MIN && state.leg_accum <= jsi_pkg::LEG_MAX)
    else $error("leg setpoint out of range");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    $signed(25'(state.roll_accum)) <= jsi_pkg::ROLL_LIMIT &&
    $signed(25'(state.roll_accum)) >= -jsi_pkg::ROLL_LIMIT)
    else $error("roll setpoint out of range");

  a_stopped_out: assert property (@(posedge clk) disable iff (rst)
    advance && !state_next.running |=>
      setpt.data.speed_target == 32'sd0 && !setpt.data.leg_changing &&
      !setpt.data.run_mode)
    else $error("stopped result carries motion");

endmodule

### tb/testbench.sv
module testbench;

  localparam int TICK = 10;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 5;

  localparam logic [4:0] KEY_NONE      = 5'd0;
  localparam logic [4:0] KEY_RUN       = 5'd4;
  localparam logic [4:0] KEY_ROLL_ZERO = 5'd9;

  localparam longint STICK_HI   = 192;
  localparam longint STICK_LO   = 64;
  localparam longint X_CENTER   = 127;
  localparam longint Y_CENTER   = 128;
  localparam longint SPEED_GAIN = -83886;
  localparam longint TURN_GAIN  = -3355;
  localparam longint ROLL_GAIN  = 1174;
  localparam longint LEG_GAIN   = -252;
  localparam longint ROLL_LIMIT = 6710887;
  localparam longint LEG_MIN    = 1090519;
  localparam longint LEG_MAX    = 3019899;
  localparam longint LEG_REST   = 1342177;
  localparam longint LEG_THRESH = 1677;
  localparam int     PITCH_LO   = 13176795;
  localparam int     PITCH_HI   = 26353589;
  localparam longint S32_MAX    = 64'sd2147483647;
  localparam longint S32_MIN    = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst;

  jsi_poll_if  poll();
  jsi_setpt_if setpt();

  joystick_setpoint_integrator #(.TICK_MS(TICK)) dut (
    .clk  (clk),
    .rst  (rst),
    .poll (poll),
    .setpt(setpt)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted block state
  logic [4:0] prior_key;
  bit         run_on;
  bit         recover_on;
  int         pos_acc;
  int         head_acc;
  int         roll_acc;
  int         leg_acc;
  int         prev_leg;

  jsi_pkg::setpt_t setpoints_due[$];

  int  errors = 0;
  int  n_polls = 0;
  int  n_setpts = 0;
  int  n_switches = 0;
  int  n_arms = 0;
  int  n_limits = 0;
  int  idle_cycles = 0;
  bit  steady;
  int  hold_asks = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  int  sink_gap = 0;

  function automatic void reset_model();
    prior_key  = KEY_NONE;
    run_on     = 1'b0;
    recover_on = 1'b0;
    pos_acc    = 0;
    head_acc   = 0;
    roll_acc   = 0;
    leg_acc    = int'(LEG_REST);
    prev_leg   = 0;
  endfunction

  function automatic longint limit_to(longint v, longint lo, longint hi);
    if (v < lo || v > hi) begin
      n_limits++;
      return (v < lo) ? lo : hi;
    end
    return v;
  endfunction

  function automatic jsi_pkg::setpt_t next_setpoint(jsi_pkg::poll_t p);
    jsi_pkg::setpt_t r;
    longint lx, ly, rx, ry, tilt, speed, drift;
    bit moved;
    lx = longint'(p.left_x);
    ly = longint'(p.left_y);
    rx = longint'(p.right_x);
    ry = longint'(p.right_y);
    speed = 0;
    moved = 1'b0;
    // cross-axis lockout: Y extreme wins, then X extreme
    if (ry > STICK_HI || ry < STICK_LO) rx = X_CENTER;
    if (rx > STICK_HI || rx < STICK_LO) ry = Y_CENTER;
    if (prior_key != KEY_RUN && p.key_code == KEY_RUN) begin
      n_switches++;
      if (!run_on) begin
        tilt = longint'(p.body_pitch);
        if (tilt < 0) tilt = -tilt;
        run_on = 1'b1;
        if (!recover_on && tilt >= PITCH_LO && tilt <= PITCH_HI) begin
          recover_on = 1'b1;
          n_arms++;
        end
      end else begin
        run_on = 1'b0;
        recover_on = 1'b0;
      end
    end
    prior_key = p.key_code;
    if (run_on) begin
      speed    = (ry - Y_CENTER) * SPEED_GAIN;
      pos_acc  = int'(limit_to(pos_acc + (speed * TICK) / 1000, S32_MIN, S32_MAX));
      head_acc = int'(limit_to(head_acc + (rx - X_CENTER) * TURN_GAIN, S32_MIN, S32_MAX));
      roll_acc = int'(limit_to(roll_acc + (lx - X_CENTER) * ROLL_GAIN,
                               -ROLL_LIMIT, ROLL_LIMIT));
      leg_acc  = int'(limit_to(leg_acc + (ly - Y_CENTER) * LEG_GAIN, LEG_MIN, LEG_MAX));
      drift = longint'(prev_leg) - longint'(leg_acc);
      if (drift < 0) drift = -drift;
      moved = (drift > LEG_THRESH);
      prev_leg = leg_acc;
    end else begin
      pos_acc  = p.position_estimate;
      head_acc = p.yaw_total;
      leg_acc  = int'(LEG_REST);
      roll_acc = 0;
    end
    if (p.key_code == KEY_ROLL_ZERO) roll_acc = 0;
    r.speed_target    = speed[31:0];
    r.position_target = pos_acc;
    r.turn_target     = head_acc;
    r.roll_target     = roll_acc[23:0];
    r.leg_target      = leg_acc[21:0];
    r.run_mode        = run_on;
    r.recover_request = recover_on;
    r.leg_changing    = moved;
    return r;
  endfunction

  function automatic jsi_pkg::poll_t make_poll(logic [4:0] key, logic [7:0] lx,
                                               logic [7:0] ly, logic [7:0] rx,
                                               logic [7:0] ry, logic [31:0] pitch = 0,
                                               logic [31:0] est = 0, logic [31:0] yaw = 0);
    jsi_pkg::poll_t p;
    p.key_code          = key;
    p.left_x            = lx;
    p.left_y            = ly;
    p.right_x           = rx;
    p.right_y           = ry;
    p.body_pitch        = pitch;
    p.position_estimate = est;
    p.yaw_total         = yaw;
    return p;
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] pick_stick();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 11))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd63;
      3:       return 8'd64;
      4:       return 8'd192;
      5:       return 8'd193;
      6:       return 8'd127;
      7:       return 8'd128;
      8:       return 8'd121;
      9:       return 8'd122;
      10:      return 8'd134;
      default: return 8'd135;
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_pitch();
    int v;
    case ($urandom_range(0, 5))
      0:       v = PITCH_LO;
      1:       v = PITCH_HI;
      2:       v = PITCH_LO - 1;
      3:       v = PITCH_HI + 1;
      4:       v = $urandom_range(PITCH_LO, PITCH_HI);
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic send_poll(input jsi_pkg::poll_t p);
    int gap;
    gap = (steady || $urandom_range(0, 9) < 6) ? 0 : pick_gap();
    if (gap > 0) begin
      poll.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    poll.valid <= 1'b1;
    poll.data  <= p;
    do @(posedge clk); while (!poll.ready);
    setpoints_due.push_back(next_setpoint(p));
    n_polls++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      setpt.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_served) begin
      setpt.ready <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
    end else if (sink_gap > 0) begin
      setpt.ready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else if (!steady && $urandom_range(0, 4) == 0) begin
      setpt.ready <= 1'b0;
      sink_gap <= pick_gap() - 1;
    end else begin
      setpt.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    jsi_pkg::setpt_t want;
    if (!rst && setpt.valid && setpt.ready) begin
      if (setpoints_due.size() == 0) begin
        $display("%0t unexpected setpoint: expected none actual %h", $time, setpt.data);
        errors++;
      end else begin
        want = setpoints_due.pop_front();
        check_field("speed_target", want.speed_target, setpt.data.speed_target);
        check_field("position_target", want.position_target, setpt.data.position_target);
        check_field("turn_target", want.turn_target, setpt.data.turn_target);
        check_field("roll_target", 32'(want.roll_target), 32'(setpt.data.roll_target));
        check_field("leg_target", 32'(want.leg_target), 32'(setpt.data.leg_target));
        check_field("run_mode", 32'(want.run_mode), 32'(setpt.data.run_mode));
        check_field("recover_request", 32'(want.recover_request),
                    32'(setpt.data.recover_request));
        check_field("leg_changing", 32'(want.leg_changing), 32'(setpt.data.leg_changing));
        n_setpts++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (poll.valid && poll.ready) || (setpt.valid && setpt.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no request moved for %0d cycles", $time, idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_lockout();
    send_poll(make_poll(KEY_RUN, 127, 128, 200, 128));
    send_poll(make_poll(KEY_NONE, 127, 128, 10, 100));
    send_poll(make_poll(KEY_NONE, 127, 128, 100, 193));
    send_poll(make_poll(KEY_NONE, 127, 128, 100, 63));
    send_poll(make_poll(KEY_NONE, 127, 128, 200, 10));
    send_poll(make_poll(KEY_NONE, 127, 128, 192, 64));
  endtask

  task automatic test_leg_threshold();
    // 7 counts of leg gain is just over the change threshold, 6 just under
    send_poll(make_poll(KEY_NONE, 127, 121, 127, 128));
    send_poll(make_poll(KEY_NONE, 127, 122, 127, 128));
    send_poll(make_poll(KEY_NONE, 127, 135, 127, 128));
  endtask

  task automatic test_run_toggle();
    send_poll(make_poll(KEY_RUN, 127, 128, 127, 128, PITCH_LO));
    send_poll(make_poll(KEY_RUN, 127, 128, 127, 128, PITCH_LO));
    send_poll(make_poll(KEY_NONE, 127, 128, 127, 128));
    send_poll(make_poll(KEY_RUN, 127, 128, 127, 128, -PITCH_HI));
    send_poll(make_poll(KEY_NONE, 127, 128, 127, 128));
    send_poll(make_poll(KEY_RUN, 127, 128, 127, 128));
    send_poll(make_poll(KEY_NONE, 127, 128, 127, 128));
    send_poll(make_poll(KEY_RUN, 127, 128, 127, 128, PITCH_LO - 1));
    send_poll(make_poll(KEY_NONE, 127, 128, 127, 128));
    send_poll(make_poll(KEY_RUN, 127, 128, 127, 128));
    send_poll(make_poll(KEY_NONE, 127, 128, 127, 128));
    send_poll(make_poll(KEY_RUN, 127, 128, 127, 128, PITCH_HI + 1));
  endtask

  task automatic test_saturation();
    send_poll(make_poll(KEY_NONE, 127, 128, 127, 128, 0, 32'h7FFF_0000, 32'h8001_0000));
    if (run_on) begin
      send_poll(make_poll(KEY_RUN, 127, 128, 127, 128, 0, 32'h7FFF_0000, 32'h8001_0000));
      send_poll(make_poll(KEY_NONE, 127, 128, 127, 128, 0, 32'h7FFF_0000, 32'h8001_0000));
    end
    send_poll(make_poll(KEY_RUN, 127, 128, 127, 0));
    send_poll(make_poll(KEY_NONE, 127, 128, 255, 128));
  endtask

  task automatic test_roll_zero();
    send_poll(make_poll(KEY_ROLL_ZERO, 255, 128, 127, 128));
    send_poll(make_poll(KEY_NONE, 255, 128, 127, 128));
    send_poll(make_poll(KEY_ROLL_ZERO, 0, 128, 127, 128));
  endtask

  // run sessions with held stick positions, random keys as noise
  task automatic test_random_sessions(input int count);
    int stop_at;
    logic [7:0] lx, ly, rx, ry;
    logic [4:0] key;
    stop_at = n_polls + count;
    while (n_polls < stop_at) begin
      steady = ($urandom_range(0, 4) == 0);
      if (run_on ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 3) != 0))
        send_poll(make_poll(KEY_RUN, pick_stick(), pick_stick(), pick_stick(), pick_stick(),
                            pick_pitch(), pick_word(), pick_word()));
      lx = pick_stick();
      ly = pick_stick();
      rx = pick_stick();
      ry = pick_stick();
      repeat ($urandom_range(3, 40)) begin
        case ($urandom_range(0, 19))
          0:       key = KEY_ROLL_ZERO;
          1, 2:    key = 5'($urandom_range(0, 31));
          default: key = KEY_NONE;
        endcase
        if ($urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 3))
            0:       lx = pick_stick();
            1:       ly = pick_stick();
            2:       rx = pick_stick();
            default: ry = pick_stick();
          endcase
        end
        send_poll(make_poll(key, lx, ly, rx, ry, pick_pitch(), pick_word(), pick_word()));
      end
    end
    steady = 1'b0;
  endtask

  // setpoint side holds off while polls keep coming back to back
  task automatic test_backpressure();
    steady = 1'b1;
    send_poll(make_poll(KEY_NONE, 127, 128, 127, 128));
    if (!run_on) send_poll(make_poll(KEY_RUN, 127, 128, 127, 128));
    hold_asks++;
    repeat (24)
      send_poll(make_poll(KEY_NONE, pick_stick(), pick_stick(), pick_stick(), pick_stick(),
                          pick_pitch(), pick_word(), pick_word()));
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    poll.valid = 1'b0;
    poll.data = '0;
    steady = 1'b0;
    reset_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_lockout();
    test_leg_threshold();
    test_run_toggle();
    test_saturation();
    test_roll_zero();
    test_random_sessions(240);
    test_backpressure();
    test_random_sessions(240);
    poll.valid <= 1'b0;
    while (setpoints_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d polls and %0d setpoints, %0d run-mode switches, %0d recovery arms",
             n_polls, n_setpts, n_switches, n_arms);
    $display("integrators hit a clamp or saturated %0d times, %0d field errors",
             n_limits, errors);
    if (errors == 0 && setpoints_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
